@@ rtl/krt_pkg.sv @@
// keyed record table: shared types, codes, sizes and the key compare function
// no dependencies; imported by every module of the block
package krt_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int KEY_W            = 24;
  localparam int VALUE_W          = 32;
  localparam int OP_W             = 2;
  localparam int STATUS_W         = 3;

  // request codes carried in the input tuser
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_LIST   = 2'd3
  } krt_op_t;

  // result codes carried in the output tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED      = 3'd0,
    ST_FULL       = 3'd1,
    ST_FOUND      = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_DELETED    = 3'd4,
    ST_LIST_ENTRY = 3'd5,
    ST_LIST_EMPTY = 3'd6
  } krt_status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } krt_state_t;

  // one record held in a cell
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } krt_rec_t;

  // commands from the controller to the row of cells
  typedef struct packed {
    logic               cmp;
    logic               push;
    logic               pull;
    logic               rot;
    logic [KEY_W-1:0]   new_key;
    logic [VALUE_W-1:0] new_value;
  } krt_cmd_t;

  // what the row of cells reports back to the controller
  typedef struct packed {
    logic               full;
    logic               hit;
    logic [KEY_W-1:0]   hit_key;
    logic [VALUE_W-1:0] hit_value;
    logic [KEY_W-1:0]   head_key;
    logic [VALUE_W-1:0] head_value;
  } krt_view_t;

  // bounded string compare over three bytes, first byte high
  function automatic logic krt_keys_equal(input logic [KEY_W-1:0] a,
                                          input logic [KEY_W-1:0] b);
    logic e0;
    logic e1;
    logic e2;
    e0 = (a[23:16] == b[23:16]);
    e1 = (a[15:8] == b[15:8]);
    e2 = (a[7:0] == b[7:0]);
    return e0 && ((a[23:16] == 8'd0) || (e1 && ((a[15:8] == 8'd0) || e2)));
  endfunction

endpackage

@@ rtl/krt_cell.sv @@
// keyed record table: one storage cell of the record row
// depends on krt_pkg; instantiated once per slot by the top level
module krt_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  krt_pkg::krt_cmd_t      cmd,
  input  logic                   pull,
  input  logic [krt_pkg::KEY_W-1:0] cmp_key,
  input  krt_pkg::krt_rec_t      prev,
  input  krt_pkg::krt_rec_t      next,
  input  krt_pkg::krt_rec_t      head,
  output krt_pkg::krt_rec_t      rec,
  output logic                   match
);
  import krt_pkg::*;

  krt_rec_t rec_next;

  // pick the neighbor to take from
  always_comb begin
    rec_next = rec;
    if (cmd.push) begin
      rec_next = prev;
    end else if (pull) begin
      rec_next = next;
    end else if (cmd.rot && rec.valid) begin
      rec_next = next.valid ? next : head;
    end
  end

  // record payload, occupancy and match flag
  always_ff @(posedge clk) begin
    rec.key   <= rec_next.key;
    rec.value <= rec_next.value;
    if (rst) begin
      rec.valid <= 1'b0;
      match     <= 1'b0;
    end else begin
      rec.valid <= rec_next.valid;
      if (cmd.cmp) begin
        match <= rec.valid && krt_keys_equal(cmp_key, rec.key);
      end
    end
  end

endmodule

@@ rtl/krt_ctrl.sv @@
// keyed record table: request sequencer, record count and output register
// depends on krt_pkg; drives the cell row commands of the top level
module krt_ctrl #(
  parameter int CAPACITY = krt_pkg::CAPACITY_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [krt_pkg::OP_W-1:0]     in_opcode,
  input  logic [krt_pkg::KEY_W-1:0]    in_key,
  input  logic [krt_pkg::VALUE_W-1:0]  in_value,
  output krt_pkg::krt_cmd_t            cmd,
  input  krt_pkg::krt_view_t           view,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [krt_pkg::STATUS_W-1:0] out_status,
  output logic [krt_pkg::KEY_W-1:0]    out_key,
  output logic [krt_pkg::VALUE_W-1:0]  out_value,
  output logic                         out_last
);
  import krt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  krt_state_t         state;
  krt_state_t         state_next;
  krt_op_t            op;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   rem;

  logic               out_free;
  logic               load;
  krt_status_t        ld_status;
  logic [KEY_W-1:0]   ld_key;
  logic [VALUE_W-1:0] ld_value;
  logic               ld_last;
  logic               cnt_inc;
  logic               cnt_dec;
  logic               rem_load;
  logic               rem_dec;

  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (op == OP_LIST && count != '0) state_next = S_LIST;
        else if (out_free) state_next = S_IDLE;
      end
      S_LIST: begin
        if (out_free && rem == CNT_W'(1)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // commands and result selection
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.new_key   = key_r;
    cmd.new_value = value_r;
    load          = 1'b0;
    ld_status     = ST_ADDED;
    ld_key        = '0;
    ld_value      = '0;
    ld_last       = 1'b1;
    cnt_inc       = 1'b0;
    cnt_dec       = 1'b0;
    rem_load      = 1'b0;
    rem_dec       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cmp  = in_valid;
      end
      S_EXEC: begin
        case (op)
          OP_ADD: begin
            if (out_free) begin
              load = 1'b1;
              if (view.full) begin
                ld_status = ST_FULL;
              end else begin
                ld_status = ST_ADDED;
                cmd.push  = 1'b1;
                cnt_inc   = 1'b1;
              end
            end
          end
          OP_SEARCH: begin
            if (out_free) begin
              load = 1'b1;
              if (view.hit) begin
                ld_status = ST_FOUND;
                ld_key    = view.hit_key;
                ld_value  = view.hit_value;
              end else begin
                ld_status = ST_NOT_FOUND;
              end
            end
          end
          OP_DELETE: begin
            if (out_free) begin
              load = 1'b1;
              if (view.hit) begin
                ld_status = ST_DELETED;
                cmd.pull  = 1'b1;
                cnt_dec   = 1'b1;
              end else begin
                ld_status = ST_NOT_FOUND;
              end
            end
          end
          OP_LIST: begin
            if (count != '0) begin
              rem_load = 1'b1;
            end else if (out_free) begin
              load      = 1'b1;
              ld_status = ST_LIST_EMPTY;
            end
          end
          default: ;
        endcase
      end
      S_LIST: begin
        if (out_free) begin
          load      = 1'b1;
          ld_status = ST_LIST_ENTRY;
          ld_key    = view.head_key;
          ld_value  = view.head_value;
          ld_last   = (rem == CNT_W'(1));
          cmd.rot   = 1'b1;
          rem_dec   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_inc) count <= count + CNT_W'(1);
      else if (cnt_dec) count <= count - CNT_W'(1);
      if (rem_load) rem <= count;
      else if (rem_dec) rem <= rem - CNT_W'(1);
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op      <= krt_op_t'(in_opcode);
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (load) begin
      out_status <= ld_status;
      out_key    <= ld_key;
      out_value  <= ld_value;
      out_last   <= ld_last;
    end
  end

endmodule

@@ rtl/keyed_record_table_core.sv @@
// keyed record table top level: row of record cells, match selection, sequencer
// depends on krt_pkg, krt_cell and krt_ctrl
//
//  channel | dir | tdata                      | tuser         | tlast
//  s_axis  | in  | key[23:0] value[55:24]     | opcode[1:0]   | -
//  m_axis  | out | key[23:0] value[55:24]     | status[2:0]   | last result
//
// add, search and delete use the transfer cycle, where every cell compares its key,
// and then the exec state, which selects the newest match and updates the row.
// list loads the record count in the exec state, then gives one record per cycle
// from the head cell as the row rotates unless output stalls; an empty list gives one result.
// reset clears every cell valid bit at once, no clearing pass.
// a stalled output holds the sequencer in place; one request is in flight at a time.
module keyed_record_table_core #(
  parameter int CAPACITY = krt_pkg::CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // key[23:0], value[55:24]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // found_key[23:0], found_value[55:24]
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  output logic        m_axis_tlast
);
  import krt_pkg::*;

  localparam logic [CAPACITY-1:0] ONES = {CAPACITY{1'b1}};

  krt_cmd_t           cmd;
  krt_view_t          view;
  krt_rec_t           recs      [CAPACITY];
  krt_rec_t           prev_rec  [CAPACITY];
  krt_rec_t           next_rec  [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] first;
  logic [CAPACITY-1:0] upto;
  logic [KEY_W-1:0]   hit_key;
  logic [VALUE_W-1:0] hit_value;
  logic [KEY_W-1:0]   out_key;
  logic [VALUE_W-1:0] out_value;

  // row of cells, cell 0 holds the newest record
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CAPACITY-1:0] INCL = ONES >> (CAPACITY - 1 - i);
    localparam logic [CAPACITY-1:0] EXCL = ONES >> (CAPACITY - i);

    // neighbor hookup
    if (i == 0) begin : g_head
      assign prev_rec[i] = {1'b1, cmd.new_key, cmd.new_value};
    end else begin : g_body
      assign prev_rec[i] = recs[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_rec[i] = '0;
    end else begin : g_inner
      assign next_rec[i] = recs[i+1];
    end

    // newest match and the cells at or below it
    assign upto[i]  = |(match & INCL);
    assign first[i] = match[i] && !(|(match & EXCL));

    krt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .pull    (cmd.pull && upto[i]),
      .cmp_key (s_axis_tdata[23:0]),
      .prev    (prev_rec[i]),
      .next    (next_rec[i]),
      .head    (recs[0]),
      .rec     (recs[i]),
      .match   (match[i])
    );
  end

  // record of the newest match
  always_comb begin
    hit_key   = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_key   = hit_key | ({KEY_W{first[i]}} & recs[i].key);
      hit_value = hit_value | ({VALUE_W{first[i]}} & recs[i].value);
    end
  end

  assign view.full       = recs[CAPACITY-1].valid;
  assign view.hit        = |match;
  assign view.hit_key    = hit_key;
  assign view.hit_value  = hit_value;
  assign view.head_key   = recs[0].key;
  assign view.head_value = recs[0].value;

  krt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_opcode  (s_axis_tuser),
    .in_key     (s_axis_tdata[23:0]),
    .in_value   (s_axis_tdata[55:24]),
    .cmd        (cmd),
    .view       (view),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_key    (out_key),
    .out_value  (out_value),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_value, out_key};

endmodule

@@ rtl/krt_checker.sv @@
// keyed record table: port-level checks, bound to the top level
// depends on krt_pkg and keyed_record_table_core
module krt_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [55:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import krt_pkg::*;

  // one request in flight: ready drops after an input transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a request is in flight");

  // every result other than a list entry closes its request
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ST_LIST_ENTRY) |-> m_axis_tlast)
    else $error("single result without last");

  // status-only results carry no record
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == ST_ADDED || m_axis_tuser == ST_FULL ||
      m_axis_tuser == ST_NOT_FOUND || m_axis_tuser == ST_DELETED ||
      m_axis_tuser == ST_LIST_EMPTY)) |-> (m_axis_tdata == '0))
    else $error("status result with nonzero data");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind keyed_record_table_core krt_port_checks u_krt_port_checks (.*);
